// ----- rtl/gcr_pkg.sv -----
`timescale 1ns / 1ps

package gcr_pkg;

  // Block codes with a meaning of their own.
  localparam logic [2:0] CELL_AIR     = 3'd0;
  localparam logic [2:0] CELL_BEDROCK = 3'd2;
  localparam logic [2:0] CELL_WATER   = 3'd5;

  // Width of the shared divider operands.
  localparam int DIV_W = 32;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_CAMERA_X   = 3'd0,
    REG_CAMERA_Y   = 3'd1,
    REG_VIEW_DIR_X = 3'd2,
    REG_VIEW_DIR_Y = 3'd3,
    REG_PLANE_X    = 3'd4,
    REG_PLANE_Y    = 3'd5,
    REG_VIEW_PITCH = 3'd6
  } cfg_reg_t;

  // Request modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  // Which quantity the shared divider is working on.
  typedef enum logic [1:0] {
    DIV_DX   = 2'd0,
    DIV_DY   = 2'd1,
    DIV_LINE = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RAY,
    S_DX,
    S_DX_W,
    S_DY,
    S_DY_W,
    S_INIT,
    S_STEP,
    S_CHECK,
    S_PERP,
    S_LINE,
    S_LINE_W,
    S_ROWS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       mode;
    logic [6:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] block_code;
  } gcr_in_t;

  typedef struct packed {
    logic [2:0]  hit_block;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic [5:0]  wall_top;
    logic [5:0]  wall_bottom;
    logic [2:0]  texture_column;
  } gcr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr_step;
    logic     map_wr;
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     ray_calc;
    logic     side_init;
    logic     step;
    logic     check;
    logic     perp_calc;
    logic     rows_calc;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic walk_end;
  } ctrl_sts_t;

endpackage

// ----- rtl/grid_column_raycaster.sv -----
`timescale 1ns / 1ps
// Map write request: taken when not busy, no result, next request at once.
// Cast request: the result strobe follows three divisions on the shared divider and a map
// read for each of the n DDA steps taken (1..MAX_STEPS).
// One cast at a time; the result strobe lasts one cycle and cannot be stalled.
// After reset the map is cleared to air while busy is high.

module grid_column_raycaster import gcr_pkg::*; #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int MAP_SIDE       = 32,
  parameter int MAX_STEPS      = 30,
  parameter int VIEW_ROWS      = 53
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  gcr_in_t     in_data,
  output logic        out_valid,
  output gcr_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  gcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_data.mode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gcr_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .MAP_SIDE       (MAP_SIDE),
    .MAX_STEPS      (MAX_STEPS),
    .VIEW_ROWS      (VIEW_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/gcr_ram.sv -----
`timescale 1ns / 1ps

module gcr_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gcr_div.sv -----
`timescale 1ns / 1ps

module gcr_div import gcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;

  // Shift the next numerator bit into the partial remainder.
  assign trial = {rem_r, quo_r[DIV_W-1]};

  // Control of the restoring divider, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= DIV_W'(trial - {1'b0, den_r});
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- rtl/gcr_dp.sv -----
`timescale 1ns / 1ps

module gcr_dp import gcr_pkg::*; #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int MAP_SIDE       = 32,
  parameter int MAX_STEPS      = 30,
  parameter int VIEW_ROWS      = 53
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gcr_in_t     in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  output gcr_out_t    out_data
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_STEPS + 1);
  localparam logic [40:0] DELTA_HUGE = 41'h100_0000_0000;
  localparam logic signed [21:0] ROW_BASE = 22'(5 * VIEW_ROWS);
  localparam logic signed [9:0]  MAP_LIM  = 10'(MAP_SIDE);
  // Reciprocal of the column count, exact for any 22-bit column numerator.
  localparam int CAM_SH = 22 + $clog2(SCREEN_COLUMNS);
  localparam logic [23:0] CAM_MUL =
    24'(((64'd1 << CAM_SH) + 64'(SCREEN_COLUMNS - 1)) / 64'(SCREEN_COLUMNS));

  // Configuration registers.
  logic [12:0]        cam_x_r, cam_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, pl_x_r, pl_y_r;
  logic signed [2:0]  pitch_r;

  // Per-column working registers.
  logic signed [19:0] cam_r;
  logic signed [23:0] ray_x_r, ray_y_r;
  logic [40:0]        dx_r, dy_r;
  logic [47:0]        sdx_r, sdy_r;
  logic signed [9:0]  mx_r, my_r;
  logic               side_r, inmap_r;
  logic [CW-1:0]      cnt_r;
  logic [2:0]         hit_r;
  logic [31:0]        perp_r;
  logic [15:0]        line_r;
  div_sel_t           div_sel_r;
  logic [AW-1:0]      clr_cnt_r;
  gcr_out_t           out_r;

  // Column offset arithmetic.
  logic [45:0]        cam_prod, cam_quo;

  // Divider hookup.
  logic [DIV_W-1:0] div_num, div_den, div_quo;
  logic             div_done;
  logic [23:0]      mag_x, mag_y;

  // Map memory hookup.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2:0]    ram_wdata, ram_rdata;
  logic          wr_inmap;

  // Ray and step arithmetic.
  logic signed [35:0] prod_rx, prod_ry;
  logic signed [21:0] shx, shy;
  logic [8:0]         fmx, fmy;
  logic [49:0]        prod_sx, prod_sy;
  logic               go_x, hit_now;
  logic signed [9:0]  nmx, nmy, rmx, rmy;
  logic               rd_inmap;
  logic [47:0]        perp_full;

  // Row and texture arithmetic.
  logic signed [21:0] line_s, pit_s, top_n, bot_n;
  logic signed [23:0] ray_t;
  logic signed [56:0] prod_t;
  logic [15:0]        u_t;
  logic [2:0]         t_raw;
  logic               mirror;

  function automatic logic signed [21:0] div10(input logic signed [21:0] n);
    logic [20:0] mag;
    logic [41:0] p;
    logic [17:0] q;
    mag = n[21] ? 21'(-n) : n[20:0];
    p   = 42'(mag) * 42'(21'd1677722);
    q   = p[41:24];
    return n[21] ? -$signed({4'b0, q}) : $signed({4'b0, q});
  endfunction

  function automatic logic [5:0] clamp_row(input logic signed [21:0] n);
    if (n < 0) begin
      return 6'd0;
    end else if (n > 22'(VIEW_ROWS - 1)) begin
      return 6'(VIEW_ROWS - 1);
    end
    return n[5:0];
  endfunction

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= 13'd4096;
      cam_y_r <= 13'd4096;
      dir_x_r <= -16'sd16384;
      dir_y_r <= '0;
      pl_x_r  <= '0;
      pl_y_r  <= 16'sd10813;
      pitch_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X:   cam_x_r <= cfg_wdata[12:0];
        REG_CAMERA_Y:   cam_y_r <= cfg_wdata[12:0];
        REG_VIEW_DIR_X: dir_x_r <= cfg_wdata;
        REG_VIEW_DIR_Y: dir_y_r <= cfg_wdata;
        REG_PLANE_X:    pl_x_r  <= cfg_wdata;
        REG_PLANE_Y:    pl_y_r  <= cfg_wdata;
        REG_VIEW_PITCH: pitch_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep over the map after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Map write port: the clearing sweep or a write request.
  always_comb begin
    wr_inmap  = (int'(in_data.cell_x) < MAP_SIDE) && (int'(in_data.cell_y) < MAP_SIDE);
    ram_we    = cmd.clr_step || (cmd.map_wr && wr_inmap);
    ram_waddr = cmd.clr_step ? clr_cnt_r
              : AW'(int'(in_data.cell_y) * MAP_SIDE + int'(in_data.cell_x));
    ram_wdata = cmd.clr_step ? CELL_AIR : in_data.block_code;
  end

  gcr_ram #(
    .WIDTH (3),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Column offset: 2*column*16384 / SCREEN_COLUMNS by reciprocal multiplication.
  always_comb begin
    cam_prod = 46'({in_data.column, 15'b0}) * 46'(CAM_MUL);
    cam_quo  = cam_prod >> CAM_SH;
  end

  // Divider operand selection.
  always_comb begin
    mag_x = ray_x_r[23] ? 24'(-ray_x_r) : 24'(ray_x_r);
    mag_y = ray_y_r[23] ? 24'(-ray_y_r) : 24'(ray_y_r);
    case (cmd.div_sel)
      DIV_DX: begin
        div_num = DIV_W'(32'h4000_0000);
        div_den = DIV_W'(mag_x);
      end
      DIV_DY: begin
        div_num = DIV_W'(32'h4000_0000);
        div_den = DIV_W'(mag_y);
      end
      DIV_LINE: begin
        div_num = DIV_W'(VIEW_ROWS * 65536);
        div_den = perp_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Ray, side distance and DDA step logic.
  always_comb begin
    prod_rx = pl_x_r * cam_r;
    prod_ry = pl_y_r * cam_r;
    shx     = prod_rx[35:14];
    shy     = prod_ry[35:14];
    fmx     = ray_x_r[23] ? {1'b0, cam_x_r[7:0]} : 9'd256 - {1'b0, cam_x_r[7:0]};
    fmy     = ray_y_r[23] ? {1'b0, cam_y_r[7:0]} : 9'd256 - {1'b0, cam_y_r[7:0]};
    prod_sx = 50'(fmx) * 50'(dx_r);
    prod_sy = 50'(fmy) * 50'(dy_r);
    go_x    = sdx_r < sdy_r;
    nmx     = ray_x_r[23] ? mx_r - 10'sd1 : mx_r + 10'sd1;
    nmy     = ray_y_r[23] ? my_r - 10'sd1 : my_r + 10'sd1;
    rmx     = go_x ? nmx : mx_r;
    rmy     = go_x ? my_r : nmy;
    rd_inmap = !rmx[9] && !rmy[9] && (rmx < MAP_LIM) && (rmy < MAP_LIM);
    ram_raddr = AW'(int'(rmy[7:0]) * MAP_SIDE + int'(rmx[7:0]));
    hit_now = inmap_r && (ram_rdata != CELL_AIR) && (ram_rdata != CELL_WATER);
    perp_full = side_r ? sdy_r - 48'(dy_r) : sdx_r - 48'(dx_r);
  end

  // Wall rows and texture column.
  always_comb begin
    line_s = $signed({6'b0, line_r});
    pit_s  = {{19{pitch_r[2]}}, pitch_r};
    top_n  = ROW_BASE + pit_s * 22'sd10 - line_s * 22'sd7;
    bot_n  = ROW_BASE + pit_s * 22'sd10 + line_s * 22'sd3;
    ray_t  = side_r ? ray_x_r : ray_y_r;
    prod_t = $signed({1'b0, perp_r}) * ray_t;
    u_t    = {side_r ? cam_x_r[7:0] : cam_y_r[7:0], 8'b0} + prod_t[29:14];
    t_raw  = u_t[15:13];
    mirror = (!side_r && !ray_x_r[23] && (ray_x_r != 0)) || (side_r && ray_y_r[23]);
  end

  // Working registers, stepped by the controller's commands.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cam_r <= $signed({1'b0, cam_quo[18:0]}) - 20'sd16384;
    end
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (div_sel_r)
        DIV_DX:   dx_r  <= (ray_x_r == 0) ? DELTA_HUGE : 41'(div_quo);
        DIV_DY:   dy_r  <= (ray_y_r == 0) ? DELTA_HUGE : 41'(div_quo);
        DIV_LINE: line_r <= ((perp_r == 0) || (div_quo > DIV_W'(65535))) ? 16'hFFFF
                          : div_quo[15:0];
        default: ;
      endcase
    end
    if (cmd.ray_calc) begin
      ray_x_r <= {{8{dir_x_r[15]}}, dir_x_r} + {{2{shx[21]}}, shx};
      ray_y_r <= {{8{dir_y_r[15]}}, dir_y_r} + {{2{shy[21]}}, shy};
    end
    if (cmd.side_init) begin
      sdx_r  <= 48'(prod_sx[49:8]);
      sdy_r  <= 48'(prod_sy[49:8]);
      mx_r   <= {5'b0, cam_x_r[12:8]};
      my_r   <= {5'b0, cam_y_r[12:8]};
      cnt_r  <= '0;
      hit_r  <= CELL_AIR;
      side_r <= 1'b0;
    end
    if (cmd.step) begin
      if (go_x) begin
        sdx_r  <= sdx_r + 48'(dx_r);
        mx_r   <= nmx;
        side_r <= 1'b0;
      end else begin
        sdy_r  <= sdy_r + 48'(dy_r);
        my_r   <= nmy;
        side_r <= 1'b1;
      end
      inmap_r <= rd_inmap;
      cnt_r   <= cnt_r + CW'(1);
    end
    if (cmd.check && hit_now) begin
      hit_r <= ram_rdata;
    end
    if (cmd.perp_calc) begin
      perp_r <= (|perp_full[47:32]) ? 32'hFFFF_FFFF : perp_full[31:0];
    end
    if (cmd.rows_calc) begin
      out_r.hit_block      <= (hit_r == CELL_AIR) ? CELL_BEDROCK : hit_r;
      out_r.hit_side       <= side_r;
      out_r.wall_distance  <= (|perp_r[31:24]) ? 16'hFFFF : perp_r[23:8];
      out_r.wall_top       <= clamp_row(div10(top_n));
      out_r.wall_bottom    <= clamp_row(div10(bot_n));
      out_r.texture_column <= mirror ? 3'd7 - t_raw : t_raw;
    end
  end

  assign sts.clr_last = clr_cnt_r == AW'(DEPTH - 1);
  assign sts.div_done = div_done;
  assign sts.walk_end = hit_now || (cnt_r == CW'(MAX_STEPS));
  assign out_data     = out_r;

endmodule

// ----- rtl/gcr_ctrl.sv -----
`timescale 1ns / 1ps

module gcr_ctrl import gcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_mode,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_DX;
    out_valid   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_CAST) begin
            cmd.load  = 1'b1;
            state_nxt = S_RAY;
          end else begin
            cmd.map_wr = 1'b1;
          end
        end
      end
      S_RAY: begin
        cmd.ray_calc = 1'b1;
        state_nxt    = S_DX;
      end
      S_DX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DX;
        state_nxt     = S_DX_W;
      end
      S_DX_W: if (sts.div_done) state_nxt = S_DY;
      S_DY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DY;
        state_nxt     = S_DY_W;
      end
      S_DY_W: if (sts.div_done) state_nxt = S_INIT;
      S_INIT: begin
        cmd.side_init = 1'b1;
        state_nxt     = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.walk_end ? S_PERP : S_STEP;
      end
      S_PERP: begin
        cmd.perp_calc = 1'b1;
        state_nxt     = S_LINE;
      end
      S_LINE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LINE;
        state_nxt     = S_LINE_W;
      end
      S_LINE_W: if (sts.div_done) state_nxt = S_ROWS;
      S_ROWS: begin
        cmd.rows_calc = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // An accepted cast request makes the block busy.
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_CAST) |=> busy) else $error("cast not taken");

  // The divider never finishes in the cycle after it starts.
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done) else $error("divider finished too early");

endmodule
